// ===== rtl/fraclt_pkg.sv =====
// fraclt_pkg: shared types and constants for the fraction reduction block
// used by fraction_lowest_terms and its port checker; no dependencies
`timescale 1ns / 1ps

package fraclt_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_DIV_ZERO = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_GCD  = 6'b000010,
        S_REM  = 6'b000100,
        S_QN   = 6'b001000,
        S_QD   = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

// ===== rtl/fraction_lowest_terms.sv =====
// fraction_lowest_terms: reduces a signed fraction to lowest terms
// uses fraclt_pkg for status codes and the sequencer state type
`timescale 1ns / 1ps

// Reduces i_num_in / i_den_in to lowest terms with Euclid's algorithm on the signed values
// (truncating remainder) followed by division of both values by the divisor found, repeated
// until that divisor is one (at most three passes). All remainders and quotients come from a
// single restoring divider that resolves one quotient bit per cycle. Each Euclid remainder
// step is set up in S_GCD and run on the divider in S_REM, and a pass divides numerator
// and then denominator back to back (S_QN, then S_QD). The number of Euclid remainder steps
// is up to roughly 1.44 * DATA_WIDTH per divisor search, and there is usually one division
// pass. A zero denominator goes straight from S_IDLE to S_DONE. The input is stalled while
// a transaction is in progress. A zero denominator returns status ST_DIV_ZERO and a quotient
// that does not fit the width returns ST_OVERFLOW, both with zero results.
module fraction_lowest_terms #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_num_in,
    input  logic signed [DATA_WIDTH-1:0] i_den_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_num_out,
    output logic signed [DATA_WIDTH-1:0] o_den_out,
    output fraclt_pkg::t_status          o_status
);
    import fraclt_pkg::*;

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [CNT_W-1:0]      CNT_LAST  = CNT_W'(DATA_WIDTH - 1);
    localparam logic [1:0]            PASS_LAST = 2'd2;
    localparam logic [DATA_WIDTH-1:0] ONE       = DATA_WIDTH'(1);

    function automatic logic [DATA_WIDTH-1:0] f_neg(input logic [DATA_WIDTH-1:0] x);
        return ~x + ONE;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] f_mag(input logic [DATA_WIDTH-1:0] x);
        return x[DATA_WIDTH-1] ? f_neg(x) : x;
    endfunction

    t_state                r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0] r_n, n_n, r_d, n_d;
    logic [DATA_WIDTH-1:0] r_a, n_a, r_b, n_b;
    logic                  r_ovf, n_ovf;
    logic [1:0]            r_pass, n_pass;
    t_status               r_res_status, n_res_status;
    logic [DATA_WIDTH-1:0] r_num_out, n_num_out, r_den_out, n_den_out;
    t_status               r_status, n_status;
    // shared divider
    logic [DATA_WIDTH-1:0] r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic                  r_neg, n_neg;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic [DATA_WIDTH:0]   shifted, diff;
    logic                  ge;
    logic [DATA_WIDTH-1:0] step_rem, step_quo, rem_s, quo_s;
    logic                  quo_ovf, div_last;

    // one restoring step: quotient bits shift in where dividend bits shift out
    always_comb begin
        shifted  = {r_rem, r_quo[DATA_WIDTH-1]};
        diff     = shifted - {1'b0, r_dvs};
        ge       = shifted >= {1'b0, r_dvs};
        step_rem = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        step_quo = {r_quo[DATA_WIDTH-2:0], ge};
        rem_s    = r_neg ? f_neg(step_rem) : step_rem;
        quo_s    = r_neg ? f_neg(step_quo) : step_quo;
        // a same-sign quotient of 2^(W-1) does not fit
        quo_ovf  = !r_neg && step_quo[DATA_WIDTH-1];
        div_last = r_cnt == CNT_LAST;
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_n          = r_n;
        n_d          = r_d;
        n_a          = r_a;
        n_b          = r_b;
        n_ovf        = r_ovf;
        n_pass       = r_pass;
        n_res_status = r_res_status;
        n_num_out    = r_num_out;
        n_den_out    = r_den_out;
        n_status     = r_status;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_dvs        = r_dvs;
        n_neg        = r_neg;
        n_cnt        = r_cnt;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n    = $unsigned(i_num_in);
                    n_d    = $unsigned(i_den_in);
                    n_a    = $unsigned(i_num_in);
                    n_b    = $unsigned(i_den_in);
                    n_ovf  = 1'b0;
                    n_pass = 2'd0;
                    if (i_den_in == '0) begin
                        n_res_status = ST_DIV_ZERO;
                        n_state      = S_DONE;
                    end else begin
                        n_res_status = ST_OK;
                        n_state      = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (r_b == '0) begin
                    if (r_a == ONE || r_a == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_rem   = '0;
                        n_quo   = f_mag(r_n);
                        n_dvs   = f_mag(r_a);
                        n_neg   = r_n[DATA_WIDTH-1] ^ r_a[DATA_WIDTH-1];
                        n_cnt   = '0;
                        n_state = S_QN;
                    end
                end else begin
                    n_rem   = '0;
                    n_quo   = f_mag(r_a);
                    n_dvs   = f_mag(r_b);
                    n_neg   = r_a[DATA_WIDTH-1];
                    n_cnt   = '0;
                    n_state = S_REM;
                end
            end
            S_REM: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt + 1'b1;
                if (div_last) begin
                    n_a     = r_b;
                    n_b     = rem_s;
                    n_state = S_GCD;
                end
            end
            S_QN: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt + 1'b1;
                if (div_last) begin
                    n_n     = quo_s;
                    n_ovf   = r_ovf | quo_ovf;
                    // same divisor, now for the denominator
                    n_rem   = '0;
                    n_quo   = f_mag(r_d);
                    n_dvs   = f_mag(r_a);
                    n_neg   = r_d[DATA_WIDTH-1] ^ r_a[DATA_WIDTH-1];
                    n_cnt   = '0;
                    n_state = S_QD;
                end
            end
            S_QD: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt + 1'b1;
                if (div_last) begin
                    n_d = quo_s;
                    if (r_ovf || quo_ovf) begin
                        n_res_status = ST_OVERFLOW;
                        n_state      = S_DONE;
                    end else if (r_pass == PASS_LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_pass  = r_pass + 1'b1;
                        n_a     = r_n;
                        n_b     = quo_s;
                        n_state = S_GCD;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_num_out   = (r_res_status == ST_OK) ? r_n : '0;
                    n_den_out   = (r_res_status == ST_OK) ? r_d : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_d          <= n_d;
        r_a          <= n_a;
        r_b          <= n_b;
        r_ovf        <= n_ovf;
        r_pass       <= n_pass;
        r_res_status <= n_res_status;
        r_num_out    <= n_num_out;
        r_den_out    <= n_den_out;
        r_status     <= n_status;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_dvs        <= n_dvs;
        r_neg        <= n_neg;
        r_cnt        <= n_cnt;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_num_out   = $signed(r_num_out);
    assign o_den_out   = $signed(r_den_out);
    assign o_status    = r_status;

endmodule

// ===== rtl/fraclt_chk.sv =====
// fraclt_chk: port-level checks for fraction_lowest_terms, bound to the top level
// uses fraclt_pkg for the status codes
`timescale 1ns / 1ps

module fraclt_chk #(
    parameter int DATA_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic signed [DATA_WIDTH-1:0] i_num_in,
    input logic signed [DATA_WIDTH-1:0] i_den_in,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic signed [DATA_WIDTH-1:0] o_num_out,
    input logic signed [DATA_WIDTH-1:0] o_den_out,
    input fraclt_pkg::t_status          o_status
);
    import fraclt_pkg::*;

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // block is busy in the cycle after a transaction is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // error results carry zero values
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_num_out == '0 && o_den_out == '0))
        else $error("nonzero result with error status");

    // a good result never has a zero denominator
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |-> o_den_out != '0)
        else $error("zero denominator with ok status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_num_out) && $stable(o_den_out) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind fraction_lowest_terms fraclt_chk #(.DATA_WIDTH(DATA_WIDTH)) u_fraclt_chk (.*);
